### hdl/manchester_edge_timing_receiver_core_defines.svh
// assertion macros for the manchester edge timing receiver
// expects clk and rst_n in the scope of use
`ifndef MANCHESTER_EDGE_TIMING_RECEIVER_CORE_DEFINES_SVH
`define MANCHESTER_EDGE_TIMING_RECEIVER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MERT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MERT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MERT_ASSERT_ALWAYS(label, cond, msg)
`define MERT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hdl/mert_pkg.sv
// types and constants for the manchester edge timing receiver
// no dependencies
`timescale 1ns / 1ps
package mert_pkg;

  localparam int MAX_FRAME_BITS = 8192;
  localparam int CNT_W          = $clog2(MAX_FRAME_BITS + 1);

  localparam logic [1:0] FUNC_RISE = 2'd0;
  localparam logic [1:0] FUNC_FALL = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [1:0] REG_HALF_BIT   = 2'd0;
  localparam logic [1:0] REG_ACCEPT_WIN = 2'd1;
  localparam logic [1:0] REG_END_GAP    = 2'd2;
  localparam logic [1:0] REG_OWN_ADDR   = 2'd3;

  localparam logic [19:0] HALF_BIT_RST   = 20'd6000;
  localparam logic [19:0] ACCEPT_WIN_RST = 20'd5000;
  localparam logic [26:0] END_GAP_RST    = 27'd240000;
  localparam logic [3:0]  OWN_ADDR_RST   = 4'd3;

  localparam logic [0:0] KIND_BIT = 1'b0;
  localparam logic [0:0] KIND_END = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] timestamp;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic        bit_value;
    logic [12:0] bit_index;
    logic [3:0]  sender_addr;
    logic [3:0]  receiver_addr;
    logic        deliver_local;
    logic [13:0] bit_total;
    logic        payload_ok;
    logic        overflowed;
  } out_word_t;

endpackage

### hdl/manchester_edge_timing_receiver_core.sv
// manchester edge timing receiver, top level
// depends on mert_pkg and manchester_edge_timing_receiver_core_defines.svh
`timescale 1ns / 1ps
`include "manchester_edge_timing_receiver_core_defines.svh"
// Takes one event word (rising edge, falling edge or time tick with a 32-bit
// timestamp) per clock and gives at most one result word per event: a decoded
// bit with its index, or an end-of-frame report. An event is captured in an
// input register and resolved against the frame state once the result register
// is free; its result word is then registered in the result register, from which
// the consumer can accept it. Throughput is one word per cycle, set by the single
// window compare and state update done per word; it drops only while the result
// register is held by a stalled consumer. cfg_ready is held high; write the
// registers only while no event is in flight, since a waiting event is resolved
// with the register values current when it leaves the input register.
module manchester_edge_timing_receiver_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mert_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mert_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [26:0]         cfg_data
);
  import mert_pkg::*;

  // configuration
  logic [19:0] half_r, aw_r;
  logic [26:0] gap_r;
  logic [3:0]  own_r;

  // input stage
  in_word_t in_word_r;
  logic     in_full_r;

  // frame state
  logic             header_r, header_nxt;
  logic [31:0]      last_edge_r, last_edge_nxt;
  logic [31:0]      expected_r, expected_nxt;
  logic             rise_r, rise_nxt;
  logic [31:0]      last_fall_r, last_fall_nxt;
  logic             fall_ok_r, fall_ok_nxt;
  logic [CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0]       addr_sh_r, addr_sh_nxt;
  logic             ovf_r, ovf_nxt;

  // output stage
  out_word_t out_word_r, out_word_nxt;
  logic      out_valid_r;
  logic      has_result;

  logic        advance;
  logic        cfg_fire;
  logic [31:0] ahead, behind, since_fall;
  logic        in_win, end_hit, store_full, take, take_bit;
  logic [3:0]  sender, receiver;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign advance   = in_full_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_full_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  assign ahead      = in_word_r.timestamp - expected_r;
  assign behind     = expected_r - in_word_r.timestamp;
  assign in_win     = (ahead < {12'd0, aw_r}) || (behind < {12'd0, aw_r});
  assign since_fall = in_word_r.timestamp - last_fall_r;
  assign end_hit    = fall_ok_r && (since_fall > {5'd0, gap_r});
  assign store_full = bit_cnt_r >= CNT_W'(MAX_FRAME_BITS);

  // address nibbles for short and full frames
  always_comb begin
    sender   = addr_sh_r[3:0];
    receiver = 4'd0;
    if (bit_cnt_r >= CNT_W'(8)) begin
      sender   = addr_sh_r[7:4];
      receiver = addr_sh_r[3:0];
    end else if (bit_cnt_r >= CNT_W'(4)) begin
      case (bit_cnt_r[1:0])
        2'd0: begin
          sender   = addr_sh_r[3:0];
          receiver = 4'd0;
        end
        2'd1: begin
          sender   = addr_sh_r[4:1];
          receiver = {3'd0, addr_sh_r[0]};
        end
        2'd2: begin
          sender   = addr_sh_r[5:2];
          receiver = {2'd0, addr_sh_r[1:0]};
        end
        default: begin
          sender   = addr_sh_r[6:3];
          receiver = {1'b0, addr_sh_r[2:0]};
        end
      endcase
    end
  end

  always_comb begin
    header_nxt    = header_r;
    last_edge_nxt = last_edge_r;
    expected_nxt  = expected_r;
    rise_nxt      = rise_r;
    last_fall_nxt = last_fall_r;
    fall_ok_nxt   = fall_ok_r;
    bit_cnt_nxt   = bit_cnt_r;
    addr_sh_nxt   = addr_sh_r;
    ovf_nxt       = ovf_r;
    out_word_nxt  = '0;
    has_result    = 1'b0;
    take          = 1'b0;
    take_bit      = 1'b0;

    if (advance) begin
      case (in_word_r.func)
        FUNC_RISE: begin
          rise_nxt = 1'b1;
          if (!header_r) begin
            header_nxt    = 1'b1;
            last_edge_nxt = in_word_r.timestamp;
            expected_nxt  = in_word_r.timestamp + {11'd0, half_r, 1'b0};
          end else if (in_win) begin
            take     = 1'b1;
            take_bit = 1'b0;
          end
        end
        FUNC_FALL: begin
          if (header_r && in_win) begin
            take     = 1'b1;
            take_bit = 1'b1;
            if (rise_r) begin
              last_fall_nxt = in_word_r.timestamp;
              fall_ok_nxt   = 1'b1;
            end
          end
        end
        FUNC_TICK: begin
          if (end_hit) begin
            has_result                 = 1'b1;
            out_word_nxt.kind          = KIND_END;
            out_word_nxt.sender_addr   = sender;
            out_word_nxt.receiver_addr = receiver;
            out_word_nxt.deliver_local = (receiver == own_r);
            out_word_nxt.bit_total     = 14'(bit_cnt_r);
            out_word_nxt.payload_ok    = (bit_cnt_r >= CNT_W'(8)) &&
                                         (bit_cnt_r[3:0] == 4'd8);
            out_word_nxt.overflowed    = ovf_r;
            header_nxt    = 1'b0;
            last_edge_nxt = '0;
            expected_nxt  = {11'd0, half_r, 1'b0};
            rise_nxt      = 1'b0;
            last_fall_nxt = '0;
            fall_ok_nxt   = 1'b0;
            bit_cnt_nxt   = '0;
            addr_sh_nxt   = '0;
            ovf_nxt       = 1'b0;
          end
        end
        default: begin
        end
      endcase

      if (take) begin
        last_edge_nxt = in_word_r.timestamp;
        expected_nxt  = in_word_r.timestamp + {11'd0, half_r, 1'b0};
        if (store_full) begin
          ovf_nxt = 1'b1;
        end else begin
          if (bit_cnt_r < CNT_W'(8)) begin
            addr_sh_nxt = {addr_sh_r[6:0], take_bit};
          end
          has_result             = 1'b1;
          out_word_nxt.kind      = KIND_BIT;
          out_word_nxt.bit_value = take_bit;
          out_word_nxt.bit_index = bit_cnt_r[12:0];
          bit_cnt_nxt            = bit_cnt_r + CNT_W'(1);
        end
      end
    end

    // half-bit change moves the expected edge time
    if (cfg_fire && cfg_index == REG_HALF_BIT) begin
      expected_nxt = last_edge_nxt + {11'd0, cfg_data[19:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_BIT_RST;
      aw_r   <= ACCEPT_WIN_RST;
      gap_r  <= END_GAP_RST;
      own_r  <= OWN_ADDR_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_HALF_BIT:   half_r <= cfg_data[19:0];
        REG_ACCEPT_WIN: aw_r   <= cfg_data[19:0];
        REG_END_GAP:    gap_r  <= cfg_data;
        REG_OWN_ADDR:   own_r  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
      header_r    <= 1'b0;
      last_edge_r <= '0;
      expected_r  <= {11'd0, HALF_BIT_RST, 1'b0};
      rise_r      <= 1'b0;
      last_fall_r <= '0;
      fall_ok_r   <= 1'b0;
      bit_cnt_r   <= '0;
      addr_sh_r   <= '0;
      ovf_r       <= 1'b0;
    end else begin
      if (in_ready) begin
        in_full_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= has_result;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      header_r    <= header_nxt;
      last_edge_r <= last_edge_nxt;
      expected_r  <= expected_nxt;
      rise_r      <= rise_nxt;
      last_fall_r <= last_fall_nxt;
      fall_ok_r   <= fall_ok_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      addr_sh_r   <= addr_sh_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
    if (advance) begin
      out_word_r <= out_word_nxt;
    end
  end

  `MERT_ASSERT_ALWAYS(a_expected_tracks, expected_r == last_edge_r + {11'd0, half_r, 1'b0}, "expected edge time out of step")
  `MERT_ASSERT_ALWAYS(a_fall_needs_header, !fall_ok_r || header_r, "fall time valid without header")
  `MERT_ASSERT_ALWAYS(a_count_bound, bit_cnt_r <= CNT_W'(MAX_FRAME_BITS), "bit counter past capacity")
  `MERT_ASSERT_ALWAYS(a_ovf_only_full, !ovf_r || store_full, "overflow set before store full")
  `MERT_ASSERT_NEXT(a_end_clears, advance && in_word_r.func == FUNC_TICK && end_hit, !header_r && bit_cnt_r == '0 && out_valid_r, "frame state not cleared after end")

endmodule

### tb/manchester_edge_timing_receiver_core_test.sv
// self-checking bench for manchester_edge_timing_receiver_core: directed event rows,
// then random frames under several register settings, checked against an in-bench decoder
// depends on mert_pkg and the core's top level
`timescale 1ns / 1ps
module manchester_edge_timing_receiver_core_test;
  import mert_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int PRESSURE_PHASE = 4;
  localparam int FILL_PHASE     = 5;
  localparam int LATENCY_WAIT   = 8;

  typedef struct {
    in_word_t  ev;
    bit        typed;
    out_word_t want;
  } row_t;

  typedef struct {
    logic [19:0] half;
    logic [19:0] win;
    logic [26:0] gap;
    logic [3:0]  addr;
    int          words;
    int          mode;
  } phase_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_HALF_BIT;
  logic [26:0] cfg_data = '0;

  // decoder copy of the registers and frame state
  logic [19:0] half_bit_q   = HALF_BIT_RST;
  logic [19:0] accept_win_q = ACCEPT_WIN_RST;
  logic [26:0] end_gap_q    = END_GAP_RST;
  logic [3:0]  own_addr_q   = OWN_ADDR_RST;
  bit          header_seen_q = 1'b0;
  bit          rise_seen_q   = 1'b0;
  bit          fall_valid    = 1'b0;
  bit          overflow_seen = 1'b0;
  logic [31:0] last_edge = '0;
  logic [31:0] last_fall = '0;
  logic [13:0] bit_count = '0;
  logic [7:0]  addr_bits = '0;

  out_word_t   pending_words[$];
  int          mismatch_count = 0;
  int unsigned words_taken = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 1'b0;

  manchester_edge_timing_receiver_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic bit on_time(input logic [31:0] ts);
    logic [31:0] centre, ahead, behind;
    centre = last_edge + {half_bit_q, 1'b0};
    ahead  = ts - centre;
    behind = centre - ts;
    return (ahead < accept_win_q) || (behind < accept_win_q);
  endfunction

  task automatic clear_frame_state();
    header_seen_q = 1'b0;
    rise_seen_q   = 1'b0;
    fall_valid    = 1'b0;
    overflow_seen = 1'b0;
    last_edge     = '0;
    last_fall     = '0;
    bit_count     = '0;
    addr_bits     = '0;
  endtask

  task automatic store_bit(input logic b, input logic [31:0] ts, output bit made,
                           output out_word_t w);
    made = 1'b0;
    w = '0;
    last_edge = ts;
    if (bit_count >= MAX_FRAME_BITS) begin
      overflow_seen = 1'b1;
      return;
    end
    if (bit_count < 8) addr_bits = {addr_bits[6:0], b};
    w.kind      = KIND_BIT;
    w.bit_value = b;
    w.bit_index = bit_count[12:0];
    made = 1'b1;
    bit_count++;
  endtask

  task automatic decode_event(input in_word_t ev, output bit made, output out_word_t w);
    int unsigned k;
    logic [3:0] sender, receiver;
    made = 1'b0;
    w = '0;
    case (ev.func)
      FUNC_RISE: begin
        rise_seen_q = 1'b1;
        if (!header_seen_q) begin
          header_seen_q = 1'b1;
          last_edge = ev.timestamp;
        end else if (on_time(ev.timestamp)) begin
          store_bit(1'b0, ev.timestamp, made, w);
        end
      end
      FUNC_FALL: begin
        if (header_seen_q && on_time(ev.timestamp)) begin
          store_bit(1'b1, ev.timestamp, made, w);
          if (rise_seen_q) begin
            last_fall  = ev.timestamp;
            fall_valid = 1'b1;
          end
        end
      end
      FUNC_TICK: begin
        if (fall_valid && (ev.timestamp - last_fall) > end_gap_q) begin
          k = bit_count;
          if (k >= 8) begin
            sender   = addr_bits[7:4];
            receiver = addr_bits[3:0];
          end else if (k >= 4) begin
            sender   = 4'(addr_bits >> (k - 4));
            receiver = 4'(addr_bits & ((8'd1 << (k - 4)) - 8'd1));
          end else begin
            sender   = addr_bits[3:0];
            receiver = 4'd0;
          end
          w.kind          = KIND_END;
          w.sender_addr   = sender;
          w.receiver_addr = receiver;
          w.deliver_local = (receiver == own_addr_q);
          w.bit_total     = bit_count;
          w.payload_ok    = (k >= 8) && (((k - 8) % 16) == 0);
          w.overflowed    = overflow_seen;
          made = 1'b1;
          clear_frame_state();
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_word(input in_word_t ev, input bit typed, input out_word_t want);
    bit made;
    out_word_t word;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_taken++;
    decode_event(ev, made, word);
    if (typed) pending_words.push_back(want);
    else if (made) pending_words.push_back(word);
  endtask

  task automatic send_event(input logic [1:0] f, input logic [31:0] ts);
    in_word_t ev;
    ev.func = f;
    ev.timestamp = ts;
    push_word(ev, 1'b0, '0);
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_event(2'($urandom_range(3, 0)), $urandom());
  endtask

  task automatic send_frame(input int nbits, input bit noisy);
    logic [31:0] ts, dev;
    logic [1:0]  nf;
    logic        b, prev_b;
    bit          have_prev;
    int          i;
    if ($urandom_range(3, 0) == 0) ts = 32'hFFFF_FFFF - $urandom_range(200000, 0);
    else ts = $urandom();
    if ($urandom_range(7, 0) == 0) send_event(FUNC_FALL, ts - 32'd7);
    send_event(FUNC_RISE, ts);
    have_prev = 1'b0;
    prev_b = 1'b0;
    for (i = 0; i < nbits; i++) begin
      b = $urandom_range(1, 0);
      // line transition at the bit boundary between equal bits
      if (have_prev && b == prev_b && $urandom_range(3, 0) != 0)
        send_event(b ? FUNC_RISE : FUNC_FALL, last_edge + {12'd0, half_bit_q});
      if (noisy && $urandom_range(15, 0) == 0) begin
        nf = 2'($urandom_range(2, 0));
        if (nf == FUNC_TICK) nf = FUNC_UNUSED;
        send_event(nf, $urandom());
      end
      if (noisy && $urandom_range(9, 0) == 0)
        send_event(FUNC_TICK, last_edge + $urandom_range(half_bit_q, 0));
      dev = (accept_win_q > 1) ? $urandom_range(accept_win_q - 1, 0) : 32'd0;
      ts = last_edge + {half_bit_q, 1'b0};
      ts = $urandom_range(1, 0) ? ts + dev : ts - dev;
      send_event(b ? FUNC_FALL : FUNC_RISE, ts);
      prev_b = b;
      have_prev = 1'b1;
    end
    if (fall_valid && $urandom_range(3, 0) == 0) send_event(FUNC_TICK, last_fall + end_gap_q);
    send_event(FUNC_TICK, last_fall + end_gap_q + 32'd1 + $urandom_range(3, 0));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [26:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_HALF_BIT:   half_bit_q   = val[19:0];
      REG_ACCEPT_WIN: accept_win_q = val[19:0];
      REG_END_GAP:    end_gap_q    = val[26:0];
      REG_OWN_ADDR:   own_addr_q   = val[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (LATENCY_WAIT) @(negedge clk);
  endtask

  function automatic out_word_t bit_word(input logic v, input logic [12:0] idx);
    out_word_t w;
    w = '0;
    w.kind = KIND_BIT;
    w.bit_value = v;
    w.bit_index = idx;
    return w;
  endfunction

  function automatic out_word_t end_word(input logic [3:0] s, input logic [3:0] r,
                                         input logic d, input logic [13:0] total,
                                         input logic ok, input logic ovf);
    out_word_t w;
    w = '0;
    w.kind = KIND_END;
    w.sender_addr = s;
    w.receiver_addr = r;
    w.deliver_local = d;
    w.bit_total = total;
    w.payload_ok = ok;
    w.overflowed = ovf;
    return w;
  endfunction

  function automatic row_t plain_row(input logic [1:0] f, input logic [31:0] ts);
    row_t r;
    r.ev.func = f;
    r.ev.timestamp = ts;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t typed_row(input logic [1:0] f, input logic [31:0] ts,
                                     input out_word_t w);
    row_t r;
    r = plain_row(f, ts);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  task automatic compare_word(input out_word_t want, input out_word_t got);
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      mismatch_count++;
    end
    if (got.bit_value !== want.bit_value) begin
      $error("bit_value: expected %0d, got %0d", want.bit_value, got.bit_value);
      mismatch_count++;
    end
    if (got.bit_index !== want.bit_index) begin
      $error("bit_index: expected %0d, got %0d", want.bit_index, got.bit_index);
      mismatch_count++;
    end
    if (got.sender_addr !== want.sender_addr) begin
      $error("sender_addr: expected %0d, got %0d", want.sender_addr, got.sender_addr);
      mismatch_count++;
    end
    if (got.receiver_addr !== want.receiver_addr) begin
      $error("receiver_addr: expected %0d, got %0d", want.receiver_addr, got.receiver_addr);
      mismatch_count++;
    end
    if (got.deliver_local !== want.deliver_local) begin
      $error("deliver_local: expected %0d, got %0d", want.deliver_local, got.deliver_local);
      mismatch_count++;
    end
    if (got.bit_total !== want.bit_total) begin
      $error("bit_total: expected %0d, got %0d", want.bit_total, got.bit_total);
      mismatch_count++;
    end
    if (got.payload_ok !== want.payload_ok) begin
      $error("payload_ok: expected %0d, got %0d", want.payload_ok, got.payload_ok);
      mismatch_count++;
    end
    if (got.overflowed !== want.overflowed) begin
      $error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_words
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("decoded word with none pending: %h", out_data);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        compare_word(want, out_data);
      end
    end
  end

  initial begin : drive_ready
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  initial begin : run
    row_t        opening_rows[$];
    phase_t      phases[6];
    int          p, goal, nbits, spin;
    bit          paused;

    // reset registers, frame 10110011 then a one-bit frame across the wrap
    opening_rows.push_back(plain_row(FUNC_FALL, 32'd100));
    opening_rows.push_back(plain_row(FUNC_RISE, 32'd1000));
    opening_rows.push_back(typed_row(FUNC_FALL, 32'd13000, bit_word(1'b1, 13'd0)));
    opening_rows.push_back(typed_row(FUNC_RISE, 32'd29999, bit_word(1'b0, 13'd1)));
    opening_rows.push_back(plain_row(FUNC_RISE, 32'd46999));
    opening_rows.push_back(typed_row(FUNC_FALL, 32'd37000, bit_word(1'b1, 13'd2)));
    opening_rows.push_back(plain_row(FUNC_TICK, 32'd40000));
    opening_rows.push_back(typed_row(FUNC_FALL, 32'd49000, bit_word(1'b1, 13'd3)));
    opening_rows.push_back(typed_row(FUNC_RISE, 32'd61000, bit_word(1'b0, 13'd4)));
    opening_rows.push_back(typed_row(FUNC_RISE, 32'd73000, bit_word(1'b0, 13'd5)));
    opening_rows.push_back(typed_row(FUNC_FALL, 32'd85000, bit_word(1'b1, 13'd6)));
    opening_rows.push_back(typed_row(FUNC_FALL, 32'd97000, bit_word(1'b1, 13'd7)));
    opening_rows.push_back(plain_row(FUNC_TICK, 32'd337000));
    opening_rows.push_back(typed_row(FUNC_TICK, 32'd337001,
                                     end_word(4'hB, 4'h3, 1'b1, 14'd8, 1'b1, 1'b0)));
    opening_rows.push_back(plain_row(FUNC_UNUSED, 32'hFFFF_FFFF));
    opening_rows.push_back(plain_row(FUNC_TICK, 32'hFFFF_FFFF));
    opening_rows.push_back(plain_row(FUNC_RISE, 32'hFFFF_FF00));
    opening_rows.push_back(typed_row(FUNC_FALL, 32'h0000_2DE0, bit_word(1'b1, 13'd0)));
    opening_rows.push_back(typed_row(FUNC_TICK, 32'd251745,
                                     end_word(4'h1, 4'h0, 1'b0, 14'd1, 1'b0, 1'b0)));
    opening_rows.push_back(plain_row(FUNC_TICK, 32'd0));

    phases = '{
      '{20'd6000,    20'd5000,    27'd240000,    4'd3,  150, 0},
      '{20'd1,       20'd1000000, 27'd1,         4'd0,  100, 0},
      '{20'd1000000, 20'd1000000, 27'd100000000, 4'd15, 150, 1},
      '{20'd500,     20'd0,       27'd3000,      4'd7,  80,  1},
      '{20'd37,      20'd20,      27'd900,       4'd10, 150, 2},
      '{20'd6000,    20'd5000,    27'd240000,    4'd3,  100, 2}
    };

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 35;
    recv_idle_pct = 74;
    foreach (opening_rows[r]) push_word(opening_rows[r].ev, opening_rows[r].typed,
                                        opening_rows[r].want);

    for (p = 0; p < 6; p++) begin
      settle();
      write_reg(REG_HALF_BIT, 27'(phases[p].half));
      write_reg(REG_ACCEPT_WIN, 27'(phases[p].win));
      write_reg(REG_END_GAP, phases[p].gap);
      write_reg(REG_OWN_ADDR, 27'(phases[p].addr));
      @(negedge clk);
      cfg_valid <= 1'b0;
      case (phases[p].mode)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (p == PRESSURE_PHASE) hold_req = 1'b1;
      paused = 1'b0;
      goal = words_taken + phases[p].words;
      while (words_taken < goal) begin
        // sender stops until the block has handed back everything
        if (p == PRESSURE_PHASE && !paused && words_taken + phases[p].words / 2 >= goal) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(4, 0) == 0) begin
          send_noise($urandom_range(4, 1));
        end else begin
          if ($urandom_range(3, 0) == 0) nbits = 8 + 16 * $urandom_range(2, 0);
          else nbits = $urandom_range(12, 0);
          send_frame(nbits, 1'b1);
        end
      end
      if (p == FILL_PHASE) send_frame(MAX_FRAME_BITS + 8, 1'b0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    spin = 0;
    while (pending_words.size() != 0 && spin < 50000) begin
      @(negedge clk);
      spin++;
    end
    repeat (LATENCY_WAIT) @(negedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d decoded words never arrived", pending_words.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### manchester_edge_timing_receiver_core.f
+incdir+hdl
hdl/mert_pkg.sv
hdl/manchester_edge_timing_receiver_core.sv
tb/manchester_edge_timing_receiver_core_test.sv
